FILE: rtl/u8v_pkg.sv
package u8v_pkg;

    typedef enum logic [2:0] {
        ERR_NONE          = 3'd0,
        ERR_MISSING_TRAIL = 3'd1,
        ERR_BAD_LEAD      = 3'd2,
        ERR_STRAY_TRAIL   = 3'd3,
        ERR_TRUNCATED     = 3'd4
    } err_t;

    typedef struct packed {
        logic       trail;
        logic       ascii;
        logic       stray;
        logic [2:0] len;
        logic       last;
    } class_t;

    typedef struct packed {
        logic [15:0] char_count;
        err_t        error_kind;
        logic        is_valid;
    } result_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int OUT_BITS    = 24;
    localparam int PAD_BITS    = OUT_BITS - $bits(result_t);

endpackage

FILE: rtl/u8v_front.sv
module u8v_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    output u8v_pkg::class_t     cls
);

    logic       strict_reg;
    logic [2:0] len;
    logic       trail;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strict_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            strict_reg <= cfg_wr_data;
        end
    end

    assign trail = (data_byte & 8'hC0) == 8'h80;

    always_comb
    begin
        if (strict_reg && (data_byte == 8'hC0 || data_byte == 8'hC1 || data_byte >= 8'hF5))
        begin
            len = 3'd0;
        end
        else if (data_byte <= 8'hDF)
        begin
            len = 3'd2;
        end
        else if (data_byte <= 8'hEF)
        begin
            len = 3'd3;
        end
        else if (data_byte <= 8'hF7)
        begin
            len = 3'd4;
        end
        else if (data_byte <= 8'hFB)
        begin
            len = 3'd5;
        end
        else if (data_byte <= 8'hFD)
        begin
            len = 3'd6;
        end
        else
        begin
            len = 3'd0;
        end
    end

    always_comb
    begin
        cls.trail = trail;
        cls.ascii = data_byte <= 8'h7F;
        cls.stray = trail & strict_reg;
        cls.len   = len;
        cls.last  = last_byte;
    end

endmodule

FILE: rtl/u8v_queue.sv
module u8v_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  u8v_pkg::class_t     push_data,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output u8v_pkg::class_t     head_data
);

    u8v_pkg::class_t                    mem_reg [u8v_pkg::QUEUE_DEPTH];
    logic [u8v_pkg::QUEUE_AW-1:0]       wr_ptr_reg;
    logic [u8v_pkg::QUEUE_AW-1:0]       rd_ptr_reg;
    logic [u8v_pkg::QUEUE_AW:0]         count_reg;
    logic [u8v_pkg::QUEUE_AW:0]         count_next;

    assign full       = count_reg == (u8v_pkg::QUEUE_AW+1)'(u8v_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue read while empty");

endmodule

FILE: rtl/u8v_back.sv
module u8v_back #(
    parameter int COUNT_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  u8v_pkg::class_t     head_data,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output u8v_pkg::result_t    out_data
);

    logic [2:0]             trails_left_reg;
    logic [2:0]             trails_left_next;
    u8v_pkg::err_t          first_error_reg;
    u8v_pkg::err_t          first_error_next;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [COUNT_BITS-1:0]  count_next;
    logic                   out_valid_reg;
    u8v_pkg::result_t       out_data_reg;
    u8v_pkg::result_t       res;
    logic [15:0]            shown;

    assign pop = head_valid && (!head_data.last || !out_valid_reg || out_ready);

    always_comb
    begin
        logic [2:0]    tl;
        u8v_pkg::err_t err;
        logic          start;
        tl    = trails_left_reg;
        err   = first_error_reg;
        start = 1'b0;
        if (!head_data.trail && count_reg != '1)
        begin
            count_next = count_reg + 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
        if (trails_left_reg != 3'd0)
        begin
            if (head_data.trail)
            begin
                tl = trails_left_reg - 1'b1;
            end
            else
            begin
                if (err == u8v_pkg::ERR_NONE)
                begin
                    err = u8v_pkg::ERR_MISSING_TRAIL;
                end
                tl    = 3'd0;
                start = 1'b1;
            end
        end
        else
        begin
            start = 1'b1;
        end
        if (start && !head_data.ascii)
        begin
            if (head_data.trail)
            begin
                if (head_data.stray && err == u8v_pkg::ERR_NONE)
                begin
                    err = u8v_pkg::ERR_STRAY_TRAIL;
                end
            end
            else if (head_data.len == 3'd0)
            begin
                if (err == u8v_pkg::ERR_NONE)
                begin
                    err = u8v_pkg::ERR_BAD_LEAD;
                end
                tl = 3'd0;
            end
            else
            begin
                tl = head_data.len - 1'b1;
            end
        end
        if (head_data.last && tl != 3'd0 && err == u8v_pkg::ERR_NONE)
        begin
            err = u8v_pkg::ERR_TRUNCATED;
        end
        trails_left_next = tl;
        first_error_next = err;
    end

    generate
        if (COUNT_BITS > 16)
        begin : g_wide
            assign shown = (|count_next[COUNT_BITS-1:16]) ? 16'hFFFF : count_next[15:0];
        end
        else if (COUNT_BITS == 16)
        begin : g_exact
            assign shown = count_next;
        end
        else
        begin : g_narrow
            assign shown = {{(16-COUNT_BITS){1'b0}}, count_next};
        end
    endgenerate

    always_comb
    begin
        res.char_count = shown;
        res.error_kind = first_error_next;
        res.is_valid   = first_error_next == u8v_pkg::ERR_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trails_left_reg <= 3'd0;
            first_error_reg <= u8v_pkg::ERR_NONE;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (head_data.last)
                begin
                    trails_left_reg <= 3'd0;
                    first_error_reg <= u8v_pkg::ERR_NONE;
                    count_reg       <= '0;
                end
                else
                begin
                    trails_left_reg <= trails_left_next;
                    first_error_reg <= first_error_next;
                    count_reg       <= count_next;
                end
            end
            if (pop && head_data.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head_data.last)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_trails_bound: assert property (@(posedge clk) disable iff (!rst_n)
        trails_left_reg <= 3'd5)
        else $error("more trail bytes pending than any lead allows");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop && head_data.last |=> trails_left_reg == 3'd0
            && first_error_reg == u8v_pkg::ERR_NONE && count_reg == '0)
        else $error("state not cleared after the last byte");

    a_valid_matches_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_data_reg.is_valid
            == (out_data_reg.error_kind == u8v_pkg::ERR_NONE))
        else $error("valid flag disagrees with error kind");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !(pop && head_data.last))
        else $error("pending result overwritten");

endmodule

FILE: rtl/utf8_stream_validate_count.sv
// UTF-8 validator and character counter for a byte stream.
// Input requests arrive on the s_axis channel, one byte per request, with tlast
// marking the final byte of a string. Each string yields exactly one result
// request on the m_axis channel, issued after its final byte; other bytes
// produce nothing. The result carries a valid flag, the first error kind seen
// and the saturated count of non-trail bytes.
// A single configuration bit selects strict checking; write it while idle.
// The block takes one byte per cycle while the queue is not full. An accepted
// byte enters a four-entry queue and is consumed by the checker from its head;
// a final byte also loads the result register that drives m_axis. The
// checker handles one byte per cycle; the only pause comes from a stalled
// result, which holds the queue head when it is a final byte until the result
// is taken, and s_axis_tready drops once the queue fills.
// Reset clears the queue, the checker state, the pending result and the
// strict bit.
module utf8_stream_validate_count #(
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic        s_axis_tlast,  // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // [0] is_valid, [3:1] error_kind, [19:4] char_count
);

    u8v_pkg::class_t    cls;
    u8v_pkg::class_t    head_data;
    u8v_pkg::result_t   result;
    logic               full;
    logic               push;
    logic               pop;
    logic               head_valid;

    assign s_axis_tready = !full;
    assign push          = s_axis_tvalid && !full;

    u8v_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .data_byte   (s_axis_tdata),
        .last_byte   (s_axis_tlast),
        .cls         (cls)
    );

    u8v_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (cls),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    u8v_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (result)
    );

    assign m_axis_tdata = {{u8v_pkg::PAD_BITS{1'b0}}, result};

endmodule

FILE: verif/tb_utf8_stream_validate_count.sv
`timescale 1ns / 1ps

module tb_utf8_stream_validate_count;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RX_HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES    = 6;
    localparam int RANDOM_PHASES   = 8;
    localparam int BYTES_PER_PHASE = 200;

    typedef struct {
        logic           strict_sel;
        logic [7:0]     data;
        logic           last;
        logic           typed;
        logic           exp_valid;
        u8v_pkg::err_t  exp_err;
        logic [15:0]    exp_count;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;

    logic          strict_q       = 1'b0;
    logic [2:0]    trails_pending = 3'd0;
    u8v_pkg::err_t first_fault    = u8v_pkg::ERR_NONE;
    logic [15:0]   char_tally     = 16'd0;

    u8v_pkg::result_t expected_results[$];
    logic [7:0]       text_bytes[$];
    u8v_pkg::result_t want_res;
    u8v_pkg::result_t got_res;
    int          n_fail       = 0;
    int          stuck_cycles = 0;
    bit          tx_idle_on   = 1'b1;
    bit          rx_idle_on   = 1'b1;
    bit          rx_hold_req  = 1'b0;

    stim_row_t dir_rows [25] = '{
        '{1'b0, 8'h00, 1'b1, 1'b1, 1'b1, u8v_pkg::ERR_NONE,          16'd1},
        '{1'b0, 8'h80, 1'b1, 1'b1, 1'b1, u8v_pkg::ERR_NONE,          16'd0},
        '{1'b0, 8'hC3, 1'b0, 1'b0, 1'b0, u8v_pkg::ERR_NONE,          16'd0},
        '{1'b0, 8'hBF, 1'b1, 1'b1, 1'b1, u8v_pkg::ERR_NONE,          16'd1},
        '{1'b0, 8'hFC, 1'b0, 1'b0, 1'b0, u8v_pkg::ERR_NONE,          16'd0},
        '{1'b0, 8'h80, 1'b0, 1'b0, 1'b0, u8v_pkg::ERR_NONE,          16'd0},
        '{1'b0, 8'h80, 1'b0, 1'b0, 1'b0, u8v_pkg::ERR_NONE,          16'd0},
        '{1'b0, 8'h80, 1'b0, 1'b0, 1'b0, u8v_pkg::ERR_NONE,          16'd0},
        '{1'b0, 8'h80, 1'b0, 1'b0, 1'b0, u8v_pkg::ERR_NONE,          16'd0},
        '{1'b0, 8'hBF, 1'b1, 1'b1, 1'b1, u8v_pkg::ERR_NONE,          16'd1},
        '{1'b0, 8'hFE, 1'b0, 1'b0, 1'b0, u8v_pkg::ERR_NONE,          16'd0},
        '{1'b0, 8'h7F, 1'b1, 1'b1, 1'b0, u8v_pkg::ERR_BAD_LEAD,      16'd2},
        '{1'b0, 8'hE0, 1'b0, 1'b0, 1'b0, u8v_pkg::ERR_NONE,          16'd0},
        '{1'b0, 8'h41, 1'b0, 1'b0, 1'b0, u8v_pkg::ERR_NONE,          16'd0},
        '{1'b0, 8'hFF, 1'b1, 1'b1, 1'b0, u8v_pkg::ERR_MISSING_TRAIL, 16'd3},
        '{1'b0, 8'hF0, 1'b0, 1'b0, 1'b0, u8v_pkg::ERR_NONE,          16'd0},
        '{1'b0, 8'h80, 1'b1, 1'b1, 1'b0, u8v_pkg::ERR_TRUNCATED,     16'd1},
        '{1'b1, 8'hBF, 1'b1, 1'b1, 1'b0, u8v_pkg::ERR_STRAY_TRAIL,   16'd0},
        '{1'b1, 8'hC1, 1'b0, 1'b0, 1'b0, u8v_pkg::ERR_NONE,          16'd0},
        '{1'b1, 8'h80, 1'b1, 1'b1, 1'b0, u8v_pkg::ERR_BAD_LEAD,      16'd1},
        '{1'b1, 8'hF4, 1'b0, 1'b0, 1'b0, u8v_pkg::ERR_NONE,          16'd0},
        '{1'b1, 8'h8F, 1'b0, 1'b0, 1'b0, u8v_pkg::ERR_NONE,          16'd0},
        '{1'b1, 8'hBF, 1'b0, 1'b0, 1'b0, u8v_pkg::ERR_NONE,          16'd0},
        '{1'b1, 8'hBF, 1'b1, 1'b0, 1'b0, u8v_pkg::ERR_NONE,          16'd0},
        '{1'b1, 8'hF5, 1'b1, 1'b1, 1'b0, u8v_pkg::ERR_BAD_LEAD,      16'd1}
    };

    utf8_stream_validate_count #(
        .COUNT_BITS(16)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic is_cont(logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    function automatic logic [2:0] seq_length(logic [7:0] b);
        if (strict_q && (b == 8'hC0 || b == 8'hC1 || b >= 8'hF5))
            return 3'd0;
        if (b <= 8'hDF)
            return 3'd2;
        if (b <= 8'hEF)
            return 3'd3;
        if (b <= 8'hF7)
            return 3'd4;
        if (b <= 8'hFB)
            return 3'd5;
        if (b <= 8'hFD)
            return 3'd6;
        return 3'd0;
    endfunction

    function automatic void note_fault(u8v_pkg::err_t kind);
        if (first_fault == u8v_pkg::ERR_NONE)
            first_fault = kind;
    endfunction

    function automatic void begin_sequence(logic [7:0] b);
        logic [2:0] len;
        len = seq_length(b);
        if (b[7] == 1'b0)
            return;
        if (is_cont(b))
        begin
            if (strict_q)
                note_fault(u8v_pkg::ERR_STRAY_TRAIL);
            return;
        end
        if (len == 3'd0)
        begin
            note_fault(u8v_pkg::ERR_BAD_LEAD);
            trails_pending = 3'd0;
        end
        else
        begin
            trails_pending = len - 3'd1;
        end
    endfunction

    function automatic bit utf8_predict(logic [7:0] b, logic lst,
                                        output u8v_pkg::result_t res);
        res = '0;
        if (!is_cont(b) && char_tally != 16'hFFFF)
            char_tally++;
        if (trails_pending != 3'd0)
        begin
            if (is_cont(b))
            begin
                trails_pending--;
            end
            else
            begin
                note_fault(u8v_pkg::ERR_MISSING_TRAIL);
                trails_pending = 3'd0;
                begin_sequence(b);
            end
        end
        else
        begin
            begin_sequence(b);
        end
        if (!lst)
            return 1'b0;
        if (trails_pending != 3'd0)
            note_fault(u8v_pkg::ERR_TRUNCATED);
        res.is_valid   = (first_fault == u8v_pkg::ERR_NONE);
        res.error_kind = first_fault;
        res.char_count = char_tally;
        trails_pending = 3'd0;
        first_fault    = u8v_pkg::ERR_NONE;
        char_tally     = 16'd0;
        return 1'b1;
    endfunction

    function automatic int pick_gap(bit idle_on);
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 75)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void append_char();
        int         shape;
        int         seq_len;
        int         trail_cnt;
        logic [7:0] lead;
        shape   = $urandom_range(0, 99);
        seq_len = $urandom_range(0, 9);
        if (seq_len < 4)
            seq_len = 1;
        else if (seq_len < 6)
            seq_len = 2;
        else if (seq_len < 8)
            seq_len = 3;
        else if (seq_len == 8 || (strict_q && shape < 80))
            seq_len = 4;
        else
            seq_len = $urandom_range(5, 6);
        case (seq_len)
            1: lead = 8'($urandom_range(0, 8'h7F));
            2: lead = 8'($urandom_range(strict_q ? 8'hC2 : 8'hC0, 8'hDF));
            3: lead = 8'($urandom_range(8'hE0, 8'hEF));
            4: lead = 8'($urandom_range(8'hF0, strict_q ? 8'hF4 : 8'hF7));
            5: lead = 8'($urandom_range(8'hF8, 8'hFB));
            default: lead = 8'($urandom_range(8'hFC, 8'hFD));
        endcase
        trail_cnt = seq_len - 1;
        if (shape >= 80 && shape < 88 && seq_len > 1)
            trail_cnt = $urandom_range(0, seq_len - 2);
        if (shape < 88)
        begin
            text_bytes.push_back(lead);
            repeat (trail_cnt)
                text_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
        else if (shape < 94)
        begin
            text_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
        else
        begin
            text_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic lst, input bit typed,
                             input u8v_pkg::result_t typed_res);
        u8v_pkg::result_t res;
        int               gap;
        gap = pick_gap(tx_idle_on);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= lst;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (utf8_predict(b, lst, res))
            expected_results.push_back(typed ? typed_res : res);
        @(negedge clk);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_bytes.size(); i++)
            send_byte(text_bytes[i], i == text_bytes.size() - 1, 1'b0, '0);
        text_bytes.delete();
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_strict(input logic v);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        strict_q = v;
    endtask

    // The result side stalls at random while idle gaps are on; a hold request from the
    // stimulus keeps it stalled long enough for the input queue to fill and push back.
    initial
    begin
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                stall_left  = RX_HOLD_CYCLES;
            end
            else if (stall_left == 0)
            begin
                stall_left = pick_gap(rx_idle_on);
            end
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result request with none expected: tdata %h", m_axis_tdata);
                n_fail++;
            end
            else
            begin
                want_res = expected_results.pop_front();
                got_res  = u8v_pkg::result_t'(m_axis_tdata[$bits(u8v_pkg::result_t)-1:0]);
                if (got_res.is_valid !== want_res.is_valid)
                begin
                    $error("is_valid: expected %0d, got %0d",
                           want_res.is_valid, got_res.is_valid);
                    n_fail++;
                end
                if (got_res.error_kind !== want_res.error_kind)
                begin
                    $error("error_kind: expected %0d, got %0d",
                           want_res.error_kind, got_res.error_kind);
                    n_fail++;
                end
                if (got_res.char_count !== want_res.char_count)
                begin
                    $error("char_count: expected %0d, got %0d",
                           want_res.char_count, got_res.char_count);
                    n_fail++;
                end
                if (m_axis_tdata[u8v_pkg::OUT_BITS-1 -: u8v_pkg::PAD_BITS] !== '0)
                begin
                    $error("tdata padding: expected 0, got %h",
                           m_axis_tdata[u8v_pkg::OUT_BITS-1 -: u8v_pkg::PAD_BITS]);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        u8v_pkg::result_t row_res;
        int               sent;
        int               n_chars;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].strict_sel != strict_q)
                write_strict(dir_rows[i].strict_sel);
            row_res.is_valid   = dir_rows[i].exp_valid;
            row_res.error_kind = dir_rows[i].exp_err;
            row_res.char_count = dir_rows[i].exp_count;
            send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed, row_res);
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_strict(logic'(p % 2));
            tx_idle_on = (p % 4 != 3);
            rx_idle_on = tx_idle_on;
            if (p == 2)
            begin
                rx_hold_req = 1'b1;
                tx_idle_on  = 1'b0;
            end
            sent = 0;
            while (sent < BYTES_PER_PHASE)
            begin
                if (p == 2)
                    n_chars = $urandom_range(1, 2);
                else if ($urandom_range(0, 9) == 0)
                    n_chars = $urandom_range(1, 30);
                else
                    n_chars = $urandom_range(1, 6);
                repeat (n_chars) append_char();
                sent += text_bytes.size();
                send_text();
            end
        end

        wait_drained();
        if (n_fail == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/u8v_pkg.sv
rtl/u8v_front.sv
rtl/u8v_queue.sv
rtl/u8v_back.sv
rtl/utf8_stream_validate_count.sv
verif/tb_utf8_stream_validate_count.sv
